[hdl/task_deadline_watchdog_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the task deadline watchdog unit
// Concurrent assertion wrappers on the unit clock. Defining NO_ASSERTIONS
// turns every use into an empty statement.
// ----------------------------------------------------------------------------
`ifndef TASK_DEADLINE_WATCHDOG_UNIT_MACROS_SVH
`define TASK_DEADLINE_WATCHDOG_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only outside reset.
`define TDW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TDW_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define TDW_ASSERT(label, prop, msg)
`define TDW_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[hdl/tdw_pkg.sv]
// ----------------------------------------------------------------------------
// Task deadline watchdog package
// Table sizes, derived widths, operation codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdw_pkg;

   // Table geometry.
   localparam int ENTRIES   = 16;
   localparam int TIME_BITS = 16;

   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);
   localparam int STEP_BITS = 16;
   localparam int SUM_BITS  = ((TIME_BITS > STEP_BITS) ? TIME_BITS : STEP_BITS) + 1;

   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ENTRIES);

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;
   typedef logic [SUM_BITS-1:0]  sum_type;
   typedef logic [STEP_BITS-1:0] step_type;
   typedef logic [ENTRIES-1:0]   flags_type;
   typedef logic [2:0]           op_type;

   // Operation codes.
   localparam op_type OP_ADD    = 3'd0;
   localparam op_type OP_REMOVE = 3'd1;
   localparam op_type OP_START  = 3'd2;
   localparam op_type OP_IDLE   = 3'd3;
   localparam op_type OP_TICK   = 3'd4;

endpackage

[hdl/task_deadline_watchdog_unit.sv]
// ----------------------------------------------------------------------------
// Task deadline watchdog unit
// Table of per-task deadline watchdogs: add, remove, start, idle and tick
// commands, with deadlines and elapsed times held in two synchronous memories.
// ----------------------------------------------------------------------------
//  Channel   Ports                                         Direction
//  command   start, busy, req_op, req_slot, req_timeout   in (busy out)
//  result    rsp_valid, rsp_granted_slot, rsp_success,     out, one-cycle strobe
//            rsp_kick
//  csr       csr_we, csr_wdata (tick_step)                 in, write only
//
//  A command transfers at a clock edge with start high and busy low.
//  Add, remove, start and idle give their result in the cycle after the transfer
//  and keep busy low, so a new command may follow in the next cycle.
//  A tick sweeps the memories one entry a cycle and holds busy high for the
//  whole sweep; its result appears as busy falls.
//  Reset clears the claim and run flags at once; no clearing pass is needed.
//  The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "task_deadline_watchdog_unit_macros.svh"

module task_deadline_watchdog_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_op,
   input  logic [3:0]                req_slot,
   input  logic [15:0]               req_timeout,
   output logic                      rsp_valid,
   output logic [3:0]                rsp_granted_slot,
   output logic                      rsp_success,
   output logic                      rsp_kick,
   input  logic                      csr_we,
   input  logic [15:0]               csr_wdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_TICK = 1'b1;

   logic                state_ff, state_in;
   tdw_pkg::cnt_type    rd_cnt_ff, rd_cnt_in;
   logic                pend_ff, pend_in;
   tdw_pkg::idx_type    pend_idx_ff, pend_idx_in;
   logic                kick_acc_ff, kick_acc_in;
   tdw_pkg::flags_type  in_use_ff, in_use_in;
   tdw_pkg::flags_type  running_ff, running_in;
   tdw_pkg::step_type   tick_step_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          rsp_granted_ff, rsp_granted_in;
   logic                rsp_success_ff, rsp_success_in;
   logic                rsp_kick_ff, rsp_kick_in;

   // Memories and their ports.
   tdw_pkg::time_type   dl_mem [tdw_pkg::ENTRIES];
   tdw_pkg::time_type   el_mem [tdw_pkg::ENTRIES];
   tdw_pkg::time_type   rd_dl_ff, rd_el_ff;
   tdw_pkg::idx_type    rd_addr;
   tdw_pkg::idx_type    wr_addr;
   logic                dl_we, el_we;
   tdw_pkg::time_type   dl_wdata, el_wdata;

   // Free slot search and tick arithmetic.
   tdw_pkg::flags_type  free_onehot;
   tdw_pkg::idx_type    free_idx;
   logic                table_full;
   tdw_pkg::idx_type    slot_idx;
   logic                slot_ok;
   logic                hit, expired, saturated, kick_next;
   tdw_pkg::sum_type    sum;

   assign busy             = (state_ff == ST_TICK);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_granted_ff;
   assign rsp_success      = rsp_success_ff;
   assign rsp_kick         = rsp_kick_ff;

   // The lowest clear claim bit, isolated with a single carry chain.
   assign table_full  = &in_use_ff;
   assign free_onehot = ~in_use_ff & (in_use_ff + tdw_pkg::flags_type'(1));

   always_comb begin
      free_idx = '0;
      for (int k = 0; k < tdw_pkg::ENTRIES; k++) begin
         if (free_onehot[k]) begin
            free_idx = free_idx | tdw_pkg::idx_type'(k);
         end
      end
   end

   assign slot_idx = tdw_pkg::idx_type'(req_slot);
   assign slot_ok  = (int'(req_slot) < tdw_pkg::ENTRIES);
   assign rd_addr  = rd_cnt_ff[tdw_pkg::IDX_BITS-1:0];

   assign hit       = pend_ff && in_use_ff[pend_idx_ff] && running_ff[pend_idx_ff];
   assign expired   = (rd_el_ff >= rd_dl_ff);
   assign sum       = tdw_pkg::sum_type'(rd_el_ff) + tdw_pkg::sum_type'(tick_step_ff);
   assign saturated = (sum[tdw_pkg::SUM_BITS-1:tdw_pkg::TIME_BITS] != '0);
   assign kick_next = kick_acc_ff & ~(hit & expired);

   always_comb begin
      state_in       = state_ff;
      rd_cnt_in      = rd_cnt_ff;
      pend_in        = pend_ff;
      pend_idx_in    = pend_idx_ff;
      kick_acc_in    = kick_acc_ff;
      in_use_in      = in_use_ff;
      running_in     = running_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = rsp_granted_ff;
      rsp_success_in = rsp_success_ff;
      rsp_kick_in    = rsp_kick_ff;
      dl_we          = 1'b0;
      el_we          = 1'b0;
      wr_addr        = slot_idx;
      dl_wdata       = tdw_pkg::time_type'(req_timeout);
      el_wdata       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_granted_in = '0;
               rsp_success_in = 1'b1;
               rsp_kick_in    = 1'b0;
               rsp_valid_in   = 1'b1;
               unique case (req_op)
                  tdw_pkg::OP_ADD: begin
                     rsp_success_in = ~table_full;
                     if (!table_full) begin
                        in_use_in[free_idx]  = 1'b1;
                        running_in[free_idx] = 1'b0;
                        wr_addr              = free_idx;
                        dl_we                = 1'b1;
                        el_we                = 1'b1;
                        rsp_granted_in       = 4'(free_idx);
                     end
                  end
                  tdw_pkg::OP_REMOVE: begin
                     if (slot_ok) begin
                        in_use_in[slot_idx]  = 1'b0;
                        running_in[slot_idx] = 1'b0;
                     end
                  end
                  tdw_pkg::OP_START, tdw_pkg::OP_IDLE: begin
                     if (slot_ok && in_use_ff[slot_idx]) begin
                        running_in[slot_idx] = (req_op == tdw_pkg::OP_START);
                        el_we                = 1'b1;
                     end
                  end
                  tdw_pkg::OP_TICK: begin
                     rsp_valid_in = 1'b0;
                     state_in     = ST_TICK;
                     rd_cnt_in    = '0;
                     pend_in      = 1'b0;
                     kick_acc_in  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK: begin
            // Read entry n while entry n-1, read in the previous cycle, is
            // updated; the two addresses never match.
            if (rd_cnt_ff != tdw_pkg::CNT_LAST) begin
               rd_cnt_in   = rd_cnt_ff + tdw_pkg::cnt_type'(1);
               pend_in     = 1'b1;
               pend_idx_in = rd_addr;
            end else begin
               pend_in = 1'b0;
            end
            if (hit && !expired) begin
               wr_addr  = pend_idx_ff;
               el_we    = 1'b1;
               el_wdata = saturated ? '1 : sum[tdw_pkg::TIME_BITS-1:0];
            end
            kick_acc_in = kick_next;
            if (rd_cnt_ff == tdw_pkg::CNT_LAST) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_granted_in = '0;
               rsp_success_in = 1'b1;
               rsp_kick_in    = kick_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         pend_ff      <= 1'b0;
         in_use_ff    <= '0;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         tick_step_ff <= tdw_pkg::step_type'(1);
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         pend_ff      <= pend_in;
         in_use_ff    <= in_use_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            tick_step_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff    <= pend_idx_in;
      kick_acc_ff    <= kick_acc_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_success_ff <= rsp_success_in;
      rsp_kick_ff    <= rsp_kick_in;
   end

   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[wr_addr] <= dl_wdata;
      end
      rd_dl_ff <= dl_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (el_we) begin
         el_mem[wr_addr] <= el_wdata;
      end
      rd_el_ff <= el_mem[rd_addr];
   end

   // A slot can only run while it is claimed.
   `TDW_ASSERT(a_run_implies_claim, ((running_ff & ~in_use_ff) == '0), "running free slot")
   // No result is shown while a tick sweep is still going.
   `TDW_ASSERT(a_no_rsp_in_sweep, (rsp_valid |-> !busy), "result during sweep")
   // A tick transfer starts a sweep; any other command answers next cycle.
   `TDW_ASSERT(a_tick_busy, ((start && !busy && req_op == tdw_pkg::OP_TICK) |=> busy), "tick not busy")
   `TDW_ASSERT(a_cmd_rsp, ((start && !busy && req_op != tdw_pkg::OP_TICK) |=> rsp_valid), "missing result")
   // Pending read data only exists inside a sweep.
   `TDW_ASSERT(a_pend_in_sweep, (pend_ff |-> state_ff == ST_TICK), "stray pending read")

endmodule

[tb/task_deadline_watchdog_checker.sv]
// ----------------------------------------------------------------------------
// Task deadline watchdog checker
// Watches the command, result and csr channels of the watchdog unit, keeps its
// own copy of the slot table and tick_step, predicts each result and compares
// it field by field with what the unit returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module task_deadline_watchdog_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_slot,
   input  logic [15:0] req_timeout,
   input  logic        rsp_valid,
   input  logic [3:0]  rsp_granted_slot,
   input  logic        rsp_success,
   input  logic        rsp_kick,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output int          failures,
   output int          outstanding,
   output int          results_checked,
   output int          expired_ticks,
   output int          full_adds
);

   typedef struct packed {
      logic [3:0] granted_slot;
      logic       success;
      logic       kick;
   } watchdog_result_type;

   localparam tdw_pkg::sum_type AGE_CEILING =
      tdw_pkg::sum_type'({tdw_pkg::TIME_BITS{1'b1}});

   logic                 claimed [tdw_pkg::ENTRIES];
   logic                 active  [tdw_pkg::ENTRIES];
   tdw_pkg::time_type    limit_time [tdw_pkg::ENTRIES];
   tdw_pkg::time_type    age [tdw_pkg::ENTRIES];
   tdw_pkg::step_type    step_size;
   watchdog_result_type  expected_results [$];

   // Applies one command to the slot table and returns the result it gives.
   function automatic watchdog_result_type predict_command(tdw_pkg::op_type op,
                                                           tdw_pkg::idx_type slot,
                                                           tdw_pkg::time_type timeout);
      watchdog_result_type outcome;
      tdw_pkg::sum_type    advanced;
      outcome.granted_slot = '0;
      outcome.success      = 1'b1;
      outcome.kick         = 1'b0;
      unique case (op)
         tdw_pkg::OP_ADD: begin
            outcome.success = 1'b0;
            for (int k = 0; k < tdw_pkg::ENTRIES; k++) begin
               if (!outcome.success && !claimed[k]) begin
                  claimed[k]           = 1'b1;
                  active[k]            = 1'b0;
                  limit_time[k]        = timeout;
                  age[k]               = '0;
                  outcome.granted_slot = 4'(k);
                  outcome.success      = 1'b1;
               end
            end
            if (!outcome.success)
               full_adds++;
         end
         tdw_pkg::OP_REMOVE: begin
            claimed[slot] = 1'b0;
            active[slot]  = 1'b0;
         end
         tdw_pkg::OP_START, tdw_pkg::OP_IDLE: begin
            if (claimed[slot]) begin
               active[slot] = (op == tdw_pkg::OP_START);
               age[slot]    = '0;
            end
         end
         tdw_pkg::OP_TICK: begin
            outcome.kick = 1'b1;
            for (int k = 0; k < tdw_pkg::ENTRIES; k++) begin
               if (claimed[k] && active[k]) begin
                  if (age[k] < limit_time[k]) begin
                     advanced = tdw_pkg::sum_type'(age[k]) + tdw_pkg::sum_type'(step_size);
                     age[k]   = (advanced > AGE_CEILING) ? '1 :
                                tdw_pkg::time_type'(advanced);
                  end else begin
                     outcome.kick = 1'b0;
                  end
               end
            end
            if (!outcome.kick)
               expired_ticks++;
         end
         default: ;
      endcase
      return outcome;
   endfunction

   // Results are retired before the command of the same edge is predicted: a
   // result never belongs to a command that transfers at the edge it appears.
   always @(posedge clock) begin
      watchdog_result_type oldest;
      if (reset) begin
         for (int k = 0; k < tdw_pkg::ENTRIES; k++) begin
            claimed[k]    = 1'b0;
            active[k]     = 1'b0;
            limit_time[k] = '0;
            age[k]        = '0;
         end
         step_size = tdw_pkg::step_type'(1);
         expected_results.delete();
         failures        = 0;
         outstanding     = 0;
         results_checked = 0;
         expired_ticks   = 0;
         full_adds       = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with no command waiting for one");
               failures++;
            end else begin
               oldest = expected_results.pop_front();
               results_checked++;
               if (rsp_granted_slot !== oldest.granted_slot) begin
                  $error("granted_slot mismatch: expected %0d, actual %0d",
                         oldest.granted_slot, rsp_granted_slot);
                  failures++;
               end
               if (rsp_success !== oldest.success) begin
                  $error("success mismatch: expected %0d, actual %0d",
                         oldest.success, rsp_success);
                  failures++;
               end
               if (rsp_kick !== oldest.kick) begin
                  $error("kick mismatch: expected %0d, actual %0d", oldest.kick, rsp_kick);
                  failures++;
               end
            end
         end
         if (csr_we)
            step_size = csr_wdata;
         if (start && !busy)
            expected_results.push_back(predict_command(req_op, req_slot,
                                                       tdw_pkg::time_type'(req_timeout)));
         outstanding = expected_results.size();
      end
   end

endmodule

[tb/task_deadline_watchdog_unit_tb.sv]
// ----------------------------------------------------------------------------
// Task deadline watchdog unit testbench
// Drives a directed command sequence and then random add, remove, start, idle,
// tick and unused op code traffic over several tick_step settings, with random
// sender gaps. The checker beside the unit predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module task_deadline_watchdog_unit_tb;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS    = 150;
   localparam int PHASES         = 6;
   localparam int OP_CODE_MAX    = (1 << $bits(tdw_pkg::op_type)) - 1;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_op;
   logic [3:0]  req_slot;
   logic [15:0] req_timeout;
   logic        rsp_valid;
   logic [3:0]  rsp_granted_slot;
   logic        rsp_success;
   logic        rsp_kick;
   logic        csr_we;
   logic [15:0] csr_wdata;

   int failures;
   int outstanding;
   int results_checked;
   int expired_ticks;
   int full_adds;
   int quiet_cycles = 0;
   int commands_sent = 0;
   int ticks_sent = 0;
   int step_settings = 0;
   bit steady_stretch = 1'b0;

   always #5 clock = ~clock;

   task_deadline_watchdog_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_slot         (req_slot),
      .req_timeout      (req_timeout),
      .rsp_valid        (rsp_valid),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_success      (rsp_success),
      .rsp_kick         (rsp_kick),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   task_deadline_watchdog_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_slot         (req_slot),
      .req_timeout      (req_timeout),
      .rsp_valid        (rsp_valid),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_success      (rsp_success),
      .rsp_kick         (rsp_kick),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .failures         (failures),
      .outstanding      (outstanding),
      .results_checked  (results_checked),
      .expired_ticks    (expired_ticks),
      .full_adds        (full_adds)
   );

   // Ends a run in which nothing transfers for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic issue_command(input tdw_pkg::op_type op, input tdw_pkg::idx_type slot,
                                input tdw_pkg::time_type timeout);
      start       = 1'b1;
      req_op      = op;
      req_slot    = slot;
      req_timeout = timeout;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
      commands_sent++;
      if (op == tdw_pkg::OP_TICK)
         ticks_sent++;
   endtask

   // While start is low the command fields carry noise the unit must ignore.
   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         start = 1'b0;
         repeat (cycles) begin
            req_op      = 3'($urandom);
            req_slot    = 4'($urandom);
            req_timeout = 16'($urandom);
            @(negedge clock);
         end
      end
   endtask

   task automatic pause_sender();
      start = 1'b0;
      do
         @(negedge clock);
      while (outstanding != 0);
   endtask

   task automatic drain_results();
      pause_sender();
      repeat (tdw_pkg::ENTRIES + 2) @(negedge clock);
   endtask

   task automatic write_tick_step(input tdw_pkg::step_type value);
      drain_results();
      csr_wdata = value;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we    = 1'b0;
      csr_wdata = 16'($urandom);
      step_settings++;
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_stretch || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Mostly short deadlines so that running slots actually expire.
   function automatic tdw_pkg::time_type pick_timeout();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return tdw_pkg::time_type'($urandom_range(0, 40));
      if (roll < 90)
         return tdw_pkg::time_type'($urandom_range(0, 600));
      return tdw_pkg::time_type'($urandom);
   endfunction

   task automatic random_command();
      int               roll;
      tdw_pkg::op_type  op;
      roll = $urandom_range(0, 99);
      if (roll < 25)
         op = tdw_pkg::OP_ADD;
      else if (roll < 40)
         op = tdw_pkg::OP_REMOVE;
      else if (roll < 60)
         op = tdw_pkg::OP_START;
      else if (roll < 70)
         op = tdw_pkg::OP_IDLE;
      else if (roll < 95)
         op = tdw_pkg::OP_TICK;
      else
         op = tdw_pkg::op_type'($urandom_range(int'(tdw_pkg::OP_TICK) + 1, OP_CODE_MAX));
      issue_command(op, tdw_pkg::idx_type'($urandom_range(0, tdw_pkg::ENTRIES - 1)),
                    pick_timeout());
   endtask

   task automatic random_phase(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 30 == 0)
            steady_stretch = ($urandom_range(0, 3) == 0);
         if (n == count / 2 || $urandom_range(0, 49) == 0)
            pause_sender();
         random_command();
         idle_sender(pick_gap());
      end
   endtask

   initial begin
      tdw_pkg::step_type step_value;
      reset       = 1'b1;
      start       = 1'b0;
      req_op      = tdw_pkg::OP_ADD;
      req_slot    = '0;
      req_timeout = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed sequence at the reset tick_step of one.
      issue_command(tdw_pkg::OP_ADD, 4'd0, 16'd0);
      issue_command(tdw_pkg::OP_ADD, 4'd0, 16'hFFFF);
      issue_command(tdw_pkg::OP_ADD, 4'd0, 16'd2);
      issue_command(tdw_pkg::OP_START, 4'd0, 16'd0);
      issue_command(tdw_pkg::OP_START, 4'd1, 16'd0);
      issue_command(tdw_pkg::OP_START, 4'd2, 16'd0);
      // Start and idle on slots never claimed are ignored.
      issue_command(tdw_pkg::OP_START, 4'd15, 16'd0);
      issue_command(tdw_pkg::OP_IDLE, 4'd14, 16'd0);
      // Slot 0 has a zero deadline, so it has expired before its first tick.
      issue_command(tdw_pkg::OP_TICK, 4'd0, 16'd0);
      issue_command(tdw_pkg::OP_TICK, 4'd0, 16'd0);
      issue_command(tdw_pkg::OP_IDLE, 4'd0, 16'd0);
      issue_command(tdw_pkg::OP_TICK, 4'd0, 16'd0);
      issue_command(tdw_pkg::OP_START, 4'd2, 16'd0);
      issue_command(tdw_pkg::OP_TICK, 4'd0, 16'd0);
      issue_command(tdw_pkg::OP_REMOVE, 4'd2, 16'd0);
      issue_command(tdw_pkg::OP_REMOVE, 4'd2, 16'd0);
      issue_command(tdw_pkg::OP_ADD, 4'd0, 16'd5);
      for (int code = int'(tdw_pkg::OP_TICK) + 1; code <= OP_CODE_MAX; code++)
         issue_command(tdw_pkg::op_type'(code), 4'($urandom), 16'($urandom));
      issue_command(tdw_pkg::OP_REMOVE, 4'd15, 16'hFFFF);
      issue_command(tdw_pkg::OP_TICK, 4'd15, 16'hFFFF);
      idle_sender(1);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       step_value = '0;
            1:       step_value = '1;
            2:       step_value = tdw_pkg::step_type'(1);
            3:       step_value = tdw_pkg::step_type'($urandom_range(2, 9));
            4:       step_value = tdw_pkg::step_type'($urandom_range(30000, 65535));
            default: step_value = tdw_pkg::step_type'($urandom);
         endcase
         write_tick_step(step_value);
         random_phase(PHASE_ITEMS);
      end
      drain_results();

      $display("Covered %0d commands, %0d of them ticks, over %0d tick_step settings.",
               commands_sent, ticks_sent, step_settings);
      $display("Checked %0d results: %0d ticks withheld the kick, %0d adds found the table full.",
               results_checked, expired_ticks, full_adds);
      if (failures == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
